// ===== rtl/core/hgbs_pkg.sv =====
// Shared types, constants and the key hash of the group-by-sum unit.
package hgbs_pkg;

   localparam int unsigned TABLE_DEPTH_DEFAULT = 64;
   localparam int unsigned KEY_W               = 64;
   localparam int unsigned SUM_W               = 64;
   localparam int unsigned PART_W              = 6;

   localparam logic [KEY_W-1:0] HASH_SEED = 64'd88172645463325252;
   localparam int unsigned      SHIFT_A   = 13;
   localparam int unsigned      SHIFT_B   = 7;
   localparam int unsigned      SHIFT_C   = 17;

   typedef struct packed {
      logic                    mode;
      logic signed [KEY_W-1:0] key;
      logic signed [SUM_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [PART_W-1:0]       partition;
      logic signed [KEY_W-1:0] out_key;
      logic signed [SUM_W-1:0] out_sum;
      logic                    last;
   } rsp_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic signed [SUM_W-1:0] sum;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } slot_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_FLUSH,
      ST_DRAIN
   } state_type;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_FLUSH  = 1'b1;

   function automatic logic [KEY_W-1:0] xs_hash(input logic [KEY_W-1:0] k);
      logic [KEY_W-1:0] r;
      r = HASH_SEED ^ k;
      r = r ^ (r << SHIFT_A);
      r = r ^ (r >> SHIFT_B);
      r = r ^ (r << SHIFT_C);
      return r;
   endfunction

endpackage

// ===== rtl/core/hgbs_table.sv =====
// Slot memory of keys and sums with per-slot valid flags and a registered read port.
module hgbs_table
   import hgbs_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEFAULT,
   parameter int unsigned IDX_W       = $clog2(TABLE_DEPTH)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] rd_addr,
   output slot_type         rd_slot,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  entry_type        wr_entry,
   input  logic             clear
);

   entry_type               mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]  valid_ff;
   logic                    rd_valid_ff;
   entry_type               rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      rd_entry_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_slot.valid = rd_valid_ff;
   assign rd_slot.entry = rd_entry_ff;

endmodule

// ===== rtl/core/hash_group_by_sum_with_spill_unit.sv =====
// Group-by-sum unit: hashed linear-probing table with spill and final flush.
// Insert: each probed slot passes through the READ and CHECK states.
// Flush: one slot read per cycle from the table memory, then the DRAIN state.
// Results come one per cycle at most, each held back until the next valid slot or the drain, so the last can be marked.
// Synchronous reset empties the table through its valid flags.
// Results cannot be stalled by the receiver.
module hash_group_by_sum_with_spill_unit
   import hgbs_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
   localparam int unsigned CNT_W = IDX_W + 1;

   state_type               state_ff, state_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic signed [SUM_W-1:0] value_ff, value_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [CNT_W-1:0]        fill_ff, fill_in;
   logic [CNT_W-1:0]        rd_idx_ff, rd_idx_in;
   logic                    rd_pend_ff, rd_pend_in;
   logic                    hold_valid_ff, hold_valid_in;
   entry_type               hold_ff, hold_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   logic [IDX_W-1:0]        rd_addr;
   slot_type                rd_slot;
   logic                    wr_en;
   entry_type               wr_entry;
   logic                    clear;
   logic [KEY_W-1:0]        req_hash;
   logic [KEY_W-1:0]        hold_hash;
   logic [CNT_W-1:0]        fill_next;

   hgbs_table #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .IDX_W      (IDX_W)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_slot (rd_slot),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_entry(wr_entry),
      .clear   (clear)
   );

   assign req_hash  = xs_hash(req_data.key);
   assign hold_hash = xs_hash(hold_ff.key);
   assign fill_next = fill_ff + CNT_W'(1);

   always_comb begin
      state_in      = state_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      idx_in        = idx_ff;
      fill_in       = fill_ff;
      rd_idx_in     = rd_idx_ff;
      rd_pend_in    = 1'b0;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      rd_addr       = idx_ff;
      wr_en         = 1'b0;
      wr_entry.key  = key_ff;
      wr_entry.sum  = value_ff;
      clear         = 1'b0;

      rsp_data_in.partition = PART_W'(hold_hash[IDX_W-1:0]);
      rsp_data_in.out_key   = hold_ff.key;
      rsp_data_in.out_sum   = hold_ff.sum;
      rsp_data_in.last      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               key_in        = req_data.key;
               value_in      = req_data.value;
               idx_in        = req_hash[IDX_W-1:0];
               rd_idx_in     = '0;
               hold_valid_in = 1'b0;
               if (req_data.mode == MODE_FLUSH) begin
                  state_in = ST_FLUSH;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            rd_addr  = idx_ff;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!rd_slot.valid) begin
               wr_en   = 1'b1;
               fill_in = fill_next;
               if (fill_next == CNT_W'(TABLE_DEPTH)) begin
                  rd_idx_in     = '0;
                  hold_valid_in = 1'b0;
                  state_in      = ST_FLUSH;
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (rd_slot.entry.key == key_ff) begin
               wr_en        = 1'b1;
               wr_entry.sum = rd_slot.entry.sum + value_ff;
               state_in     = ST_IDLE;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = ST_READ;
            end
         end
         ST_FLUSH: begin
            rd_addr = rd_idx_ff[IDX_W-1:0];
            if (rd_idx_ff != CNT_W'(TABLE_DEPTH)) begin
               rd_pend_in = 1'b1;
               rd_idx_in  = rd_idx_ff + CNT_W'(1);
            end else if (!rd_pend_ff) begin
               state_in = ST_DRAIN;
            end
            if (rd_pend_ff && rd_slot.valid) begin
               rsp_strobe_in = hold_valid_ff;
               hold_valid_in = 1'b1;
               hold_in       = rd_slot.entry;
            end
         end
         ST_DRAIN: begin
            rsp_strobe_in    = hold_valid_ff;
            rsp_data_in.last = 1'b1;
            hold_valid_in    = 1'b0;
            clear            = 1'b1;
            fill_in          = '0;
            state_in         = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_ff       <= '0;
         rd_idx_ff     <= '0;
         rd_pend_ff    <= 1'b0;
         hold_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         rd_idx_ff     <= rd_idx_in;
         rd_pend_ff    <= rd_pend_in;
         hold_valid_ff <= hold_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      value_ff    <= value_in;
      idx_ff      <= idx_in;
      hold_ff     <= hold_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(TABLE_DEPTH))
      else $error("fill count exceeds table depth");

   a_rsp_from_flush: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(state_ff) == ST_FLUSH || $past(state_ff) == ST_DRAIN))
      else $error("result emitted outside a flush run");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.last) |-> (state_ff == ST_IDLE && fill_ff == '0))
      else $error("last result did not end the flush run");

   a_no_write_in_flush: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH || state_ff == ST_DRAIN) |-> !wr_en)
      else $error("table written during a flush run");

endmodule
